// ===== rtl/segw_pkg.sv =====
// Shared types, codes and the glyph table of the segment LCD character writer.
// Used by the front, queue, back and top level modules; no dependencies.
package segw_pkg;

   localparam int REG_COUNT_DEFAULT = 20;
   localparam int QUEUE_DEPTH       = 2;
   localparam int DIGIT_MAX         = 5;
   localparam int PLANE_STRIDE      = 5;
   localparam int GLYPH_COUNT       = 54;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_FILL  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] FIRST_CODE = 8'h2A;
   localparam logic [7:0] LAST_CODE  = 8'h7A;
   localparam logic [7:0] LOWER_BASE = 8'h61;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_FILL  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        rejected;
      logic [15:0] pattern;
      logic        odd;
      logic [1:0]  base;
      logic        fill_on;
      logic [4:0]  reg_index;
   } cmd_type;

   localparam logic [15:0] GLYPH_ROM [GLYPH_COUNT] = '{
      16'h0A51, 16'h2A80, 16'h0000, 16'h0A00, 16'h0A51, 16'h0000,
      16'h5559, 16'h0118, 16'h1e11, 16'h1b11, 16'h0b50, 16'h1b41, 16'h1f41, 16'h0111,
      16'h1f51, 16'h1b51,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0f51, 16'h3991, 16'h1441, 16'h3191, 16'h1e41, 16'h0e41, 16'h1d41, 16'h0f50,
      16'h2080, 16'h1510, 16'h8648, 16'h1440, 16'h0578, 16'h8570, 16'h1551, 16'h0e51,
      16'h9551, 16'h8e51, 16'h9021, 16'h2081, 16'h1550, 16'h4448, 16'hc550, 16'hc028,
      16'h2028, 16'h5009,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
   };

   function automatic logic [15:0] glyph_lookup(input logic [7:0] code);
      logic [7:0]  folded;
      logic [7:0]  idx;
      logic [15:0] result;
      folded = code;
      if (code >= LOWER_BASE) begin
         folded = code & ~CASE_BIT;
      end
      idx = folded - FIRST_CODE;
      result = 16'h0000;
      if ((code inside {[FIRST_CODE:LAST_CODE]}) && idx < 8'(GLYPH_COUNT)) begin
         result = GLYPH_ROM[idx[5:0]];
      end
      return result;
   endfunction

endpackage

// ===== rtl/segw_front.sv =====
// Front end of the segment LCD character writer: accepts request words,
// range-checks them and looks up the glyph. Depends on segw_pkg.
module segw_front import segw_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_digit_pos,
   input  logic       req_fill_on,
   input  logic [4:0] req_reg_index,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   always_comb begin
      push_cmd           = '0;
      push_cmd.kind      = KIND_NONE;
      push_cmd.pattern   = glyph_lookup(req_char_code);
      push_cmd.odd       = req_digit_pos[0];
      push_cmd.base      = req_digit_pos[2:1];
      push_cmd.fill_on   = req_fill_on;
      push_cmd.reg_index = req_reg_index;
      case (req_opcode)
         OP_WRITE: begin
            if (req_digit_pos > 8'(DIGIT_MAX)) begin
               push_cmd.rejected = 1'b1;
            end else begin
               push_cmd.kind = KIND_WRITE;
            end
         end
         OP_FILL: begin
            push_cmd.kind = KIND_FILL;
         end
         OP_READ: begin
            if ({1'b0, req_reg_index} >= 6'(REG_COUNT)) begin
               push_cmd.rejected = 1'b1;
            end else begin
               push_cmd.kind = KIND_READ;
            end
         end
         default: begin
            push_cmd.kind = KIND_NONE;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

endmodule

// ===== rtl/segw_queue.sv =====
// Short command queue between the front and back ends of the character writer.
// Depends on segw_pkg for the command type and depth.
module segw_queue import segw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/segw_back.sv =====
// Back end of the character writer: holds the segment register file, carries
// out queued commands and registers the response word. Depends on segw_pkg.
module segw_back import segw_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_empty,
   input  cmd_type    cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_rejected
);

   localparam int IDX_W = $clog2(REG_COUNT);

   logic [7:0] regs_ff [REG_COUNT];
   logic [7:0] regs_in [REG_COUNT];
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic       rsp_rejected_ff, rsp_rejected_in;
   logic [4:0] pos;
   logic [3:0] nib;

   assign pop = ~cmd_empty & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      regs_in          = regs_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_rejected_in  = rsp_rejected_ff;
      pos              = '0;
      nib              = '0;
      if (pop) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = 8'h00;
         rsp_rejected_in  = cmd.rejected;
         case (cmd.kind)
            KIND_WRITE: begin
               for (int k = 0; k < 4; k++) begin
                  pos = 5'(cmd.base) + 5'(PLANE_STRIDE * k);
                  nib = cmd.pattern[4*k +: 4];
                  if ({1'b0, pos} < 6'(REG_COUNT)) begin
                     if (cmd.odd) begin
                        regs_in[pos[IDX_W-1:0]] = {nib, regs_ff[pos[IDX_W-1:0]][3:0]};
                     end else begin
                        regs_in[pos[IDX_W-1:0]] = {regs_ff[pos[IDX_W-1:0]][7:4], nib};
                     end
                  end
               end
            end
            KIND_FILL: begin
               for (int i = 0; i < REG_COUNT; i++) begin
                  regs_in[i] = cmd.fill_on ? 8'hFF : 8'h00;
               end
            end
            KIND_READ: begin
               rsp_read_data_in = regs_ff[cmd.reg_index[IDX_W-1:0]];
            end
            default: begin
               rsp_read_data_in = 8'h00;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= 8'h00;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_rejected_ff  <= rsp_rejected_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_rejected  = rsp_rejected_ff;

endmodule

// ===== rtl/segment_lcd_char_writer_core.sv =====
// Top level of the segment LCD character writer: front end, command queue and
// back end with the segment register file. Depends on segw_pkg and its modules.
//
// Usage: request words arrive on req_* (valid/stall). Opcode write maps
// req_char_code to a fourteen-segment glyph and merges its four nibbles into
// the register file for digit req_digit_pos; fill sets every register to
// 0xFF or 0x00; read returns register req_reg_index. Every request yields
// exactly one response word on rsp_*, in order, with rsp_rejected set when
// the digit or register index is out of range.
// The command waits in the two-entry queue and the back end registers the response
// word at the edge where it pops the command.
// While rsp_stall is low, throughput is one word per cycle; the back end
// executes one command per cycle on the register file.
// Reset clears the queue, the response valid flag and all segment registers.
// When the receiver holds rsp_stall, the response holds, the queue fills,
// and req_stall rises once both queue entries are taken.
module segment_lcd_char_writer_core import segw_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_digit_pos,
   input  logic       req_fill_on,
   input  logic [4:0] req_reg_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_rejected
);

   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   segw_front #(.REG_COUNT(REG_COUNT)) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_digit_pos (req_digit_pos),
      .req_fill_on   (req_fill_on),
      .req_reg_index (req_reg_index),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   segw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   segw_back #(.REG_COUNT(REG_COUNT)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (queue_empty),
      .cmd           (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_rejected  (rsp_rejected)
   );

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rejected_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_read_data == 8'h00)
      else $error("rejected response carries data");

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(queue_full && queue_empty))
      else $error("queue both full and empty");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped command produced no response");

endmodule

// ===== tb/segment_lcd_char_writer_core_tb.sv =====
// Self-checking testbench for segment_lcd_char_writer_core: directed and random request words
// under several idle and stall mixes, each response checked against a scoreboard model.
// Depends on segw_pkg and the core RTL only.
`timescale 1ns / 1ps

module segment_lcd_char_writer_core_tb;
   import segw_pkg::*;

   localparam int          REG_COUNT      = REG_COUNT_DEFAULT;
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int          GLYPH_ENTRIES  = 54;
   localparam logic [7:0]  GLYPH_FIRST    = 8'h2A;
   localparam logic [7:0]  GLYPH_LAST     = 8'h7A;
   localparam int          STALL_LIMIT    = 5000;
   localparam int          RANDOM_PER_MIX = 200;

   localparam logic [15:0] SEGMENT_FONT [GLYPH_ENTRIES] = '{
      16'h0A51, 16'h2A80, 16'h0000, 16'h0A00, 16'h0A51, 16'h0000,
      16'h5559, 16'h0118, 16'h1e11, 16'h1b11, 16'h0b50, 16'h1b41, 16'h1f41, 16'h0111,
      16'h1f51, 16'h1b51,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0f51, 16'h3991, 16'h1441, 16'h3191, 16'h1e41, 16'h0e41, 16'h1d41, 16'h0f50,
      16'h2080, 16'h1510, 16'h8648, 16'h1440, 16'h0578, 16'h8570, 16'h1551, 16'h0e51,
      16'h9551, 16'h8e51, 16'h9021, 16'h2081, 16'h1550, 16'h4448, 16'hc550, 16'hc028,
      16'h2028, 16'h5009,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
   };

   class segment_scoreboard;
      typedef struct packed {
         logic [7:0] read_data;
         logic       rejected;
      } answer_type;

      logic [7:0] segment_shadow [REG_COUNT];
      answer_type expected_answers [$];
      int         mismatch_count;

      function new();
         foreach (segment_shadow[i]) begin
            segment_shadow[i] = 8'h00;
         end
         mismatch_count = 0;
      endfunction

      function logic [15:0] pattern_for(input logic [7:0] code);
         logic [7:0] upper;
         int         slot;
         if (code < GLYPH_FIRST || code > GLYPH_LAST) begin
            return 16'h0000;
         end
         upper = (code >= 8'h61) ? (code & 8'hDF) : code;
         slot = int'(upper) - int'(GLYPH_FIRST);
         if (slot >= GLYPH_ENTRIES) begin
            return 16'h0000;
         end
         return SEGMENT_FONT[slot];
      endfunction

      function void note_request(input logic [1:0] opcode, input logic [7:0] char_code,
                                 input logic [7:0] digit_pos, input logic fill_on,
                                 input logic [4:0] reg_index);
         answer_type  answer;
         logic [15:0] pattern;
         logic [3:0]  nibble;
         int          slot;
         answer = '0;
         case (opcode)
            OP_WRITE: begin
               if (digit_pos > 8'd5) begin
                  answer.rejected = 1'b1;
               end else begin
                  pattern = pattern_for(char_code);
                  for (int k = 0; k < 4; k++) begin
                     nibble = pattern[4*k +: 4];
                     slot = int'(digit_pos >> 1) + 5 * k;
                     if (slot < REG_COUNT) begin
                        if (digit_pos[0]) begin
                           segment_shadow[slot][7:4] = nibble;
                        end else begin
                           segment_shadow[slot][3:0] = nibble;
                        end
                     end
                  end
               end
            end
            OP_FILL: begin
               foreach (segment_shadow[i]) begin
                  segment_shadow[i] = fill_on ? 8'hFF : 8'h00;
               end
            end
            OP_READ: begin
               if (int'(reg_index) >= REG_COUNT) begin
                  answer.rejected = 1'b1;
               end else begin
                  answer.read_data = segment_shadow[reg_index];
               end
            end
            default: begin
            end
         endcase
         expected_answers.push_back(answer);
      endfunction

      task report(input string what);
         $display("%0t: mismatch: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_response(input logic [7:0] read_data, input logic rejected);
         answer_type answer;
         if (expected_answers.size() == 0) begin
            report($sformatf("response word data=%02h rejected=%0b with nothing pending",
                             read_data, rejected));
            return;
         end
         answer = expected_answers.pop_front();
         if (read_data !== answer.read_data) begin
            report($sformatf("read_data %02h, expected %02h", read_data, answer.read_data));
         end
         if (rejected !== answer.rejected) begin
            report($sformatf("rejected %0b, expected %0b", rejected, answer.rejected));
         end
      endtask

      function int pending();
         return expected_answers.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode = OP_WRITE;
   logic [7:0] req_char_code = 8'h00;
   logic [7:0] req_digit_pos = 8'h00;
   logic       req_fill_on = 1'b0;
   logic [4:0] req_reg_index = 5'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_rejected;

   segment_scoreboard segment_model = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles = 0;

   segment_lcd_char_writer_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_digit_pos (req_digit_pos),
      .req_fill_on   (req_fill_on),
      .req_reg_index (req_reg_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_rejected  (rsp_rejected)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            segment_model.note_request(req_opcode, req_char_code, req_digit_pos,
                                       req_fill_on, req_reg_index);
         end
         if (rsp_valid && !rsp_stall) begin
            segment_model.check_response(rsp_read_data, rsp_rejected);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_word(input logic [1:0] opcode, input logic [7:0] char_code,
                            input logic [7:0] digit_pos, input logic fill_on,
                            input logic [4:0] reg_index);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_char_code <= char_code;
      req_digit_pos <= digit_pos;
      req_fill_on <= fill_on;
      req_reg_index <= reg_index;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_word();
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [7:0] digit_pos;
      logic [4:0] reg_index;
      int         roll;
      roll = $urandom_range(99);
      if (roll < 58) begin
         opcode = OP_WRITE;
      end else if (roll < 88) begin
         opcode = OP_READ;
      end else if (roll < 95) begin
         opcode = OP_FILL;
      end else begin
         opcode = OP_UNUSED;
      end
      char_code = ($urandom_range(99) < 70) ? 8'($urandom_range(GLYPH_LAST, GLYPH_FIRST))
                                            : 8'($urandom);
      digit_pos = ($urandom_range(99) < 88) ? 8'($urandom_range(5))
                                            : 8'($urandom_range(255, 6));
      reg_index = ($urandom_range(99) < 88) ? 5'($urandom_range(REG_COUNT - 1))
                                            : 5'($urandom_range(31, REG_COUNT));
      send_word(opcode, char_code, digit_pos, 1'($urandom), reg_index);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reads of the cleared file, then out-of-range register indexes.
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd0);
      send_word(OP_READ, 8'hFF, 8'hFF, 1'b1, 5'd19);
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd20);
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd31);
      // Table ends, lower case folding, the backquote and codes outside the table.
      send_word(OP_WRITE, 8'h2A, 8'd0, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'h7A, 8'd5, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'h61, 8'd1, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'h60, 8'd2, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'h5F, 8'd3, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'h7B, 8'd4, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'h29, 8'd4, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'hFF, 8'd0, 1'b1, 5'd31);
      // Digits past the last one are refused.
      send_word(OP_WRITE, 8'h41, 8'd6, 1'b0, 5'd0);
      send_word(OP_WRITE, 8'h41, 8'd255, 1'b0, 5'd0);
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd5);
      send_word(OP_FILL, 8'h00, 8'h00, 1'b1, 5'd0);
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd7);
      send_word(OP_WRITE, 8'h30, 8'd4, 1'b0, 5'd0);
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd2);
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd17);
      send_word(OP_UNUSED, 8'hFF, 8'hFF, 1'b1, 5'd31);
      send_word(OP_FILL, 8'h00, 8'h00, 1'b0, 5'd0);
      send_word(OP_READ, 8'h00, 8'h00, 1'b0, 5'd12);

      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
         endcase
         repeat (RANDOM_PER_MIX) send_random_word();
      end

      req_valid <= 1'b0;
      while (segment_model.pending() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (segment_model.mismatch_count == 0 && segment_model.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/segw_pkg.sv
rtl/segw_front.sv
rtl/segw_queue.sv
rtl/segw_back.sv
rtl/segment_lcd_char_writer_core.sv
tb/segment_lcd_char_writer_core_tb.sv
